>>> sv/dtd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the drift time to distance converter.
// Used by every module of the block; depends on nothing else.
package dtd_pkg;

    localparam int TIME_W      = 16;
    localparam int COEF_W      = 32;
    localparam int ACC_W       = 48;
    localparam int PROD_W      = ACC_W + TIME_W;
    localparam int EXCESS_W    = TIME_W + 1;
    localparam int TAIL_W      = COEF_W + EXCESS_W;
    localparam int OUT_W       = 32;
    localparam int ROUND_SHIFT = 14;
    localparam int MAX_ORDER   = 5;
    localparam int NUM_COEF    = MAX_ORDER + 1;
    localparam int CFG_IDX_W   = 3;

    // Half of one LSB after the shift, added before the floor shift.
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1 << (ROUND_SHIFT - 1));
    localparam logic signed [TAIL_W-1:0] TAIL_BIAS  = TAIL_W'(1 << (ROUND_SHIFT - 1));

    localparam logic signed [TIME_W-1:0] KNEE_RESET = 16'sh7FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_0 = 3'd0,
        REG_COEF_1 = 3'd1,
        REG_COEF_2 = 3'd2,
        REG_COEF_3 = 3'd3,
        REG_COEF_4 = 3'd4,
        REG_COEF_5 = 3'd5,
        REG_KNEE   = 3'd6,
        REG_SLOPE  = 3'd7
    } cfg_index_t;

    // Per-item data that travels beside the Horner accumulator.
    typedef struct packed {
        logic signed [TIME_W-1:0] t_eval;
        logic signed [TAIL_W-1:0] tail_prod;
        logic                     sat;
    } side_t;

endpackage

>>> sv/drift_time_to_distance.sv
`timescale 1ns / 1ps
// Drift time to distance converter, top level: configuration registers and pipeline.
// Depends on dtd_pkg, dtd_front, dtd_horner_step and dtd_final.
//
// Usage. Each request on the s_ channel carries one signed drift time in 1/16 ns.
// The m_ channel returns one request per input: the distance in Q8.24 millimetres
// and a flag that is set when any clamp occurred along the way. Both channels use
// valid/ready; a request moves when both are high at a rising edge of aclk.
// Below the knee time the distance is a polynomial of order ORD (at most five) in t/16384, in
// Horner form; at or above the knee it is the polynomial at the knee plus the
// tail slope times the normalized excess time.
// Throughput is one request per cycle while m_ready stays high. From input acceptance
// to m_valid a request passes two entry stages, one multiply stage and one
// round/add/clamp stage per Horner step, and two exit stages.
// Every stage has its own valid bit and advances whenever the stage after it is
// empty or moving, so the block keeps taking requests while a result waits, until
// all stages are full. A stalled receiver therefore fills the pipeline and then
// drops s_ready; nothing is lost or repeated.
// Configuration writes through cfg_wr_en, cfg_index and cfg_wdata take effect at
// once and are meant to happen only while the pipeline is empty.
// A synchronous low aresetn empties the pipeline and returns the registers to
// their defaults: all coefficients and the slope zero, the knee at the largest time.
module drift_time_to_distance import dtd_pkg::*; #(
    parameter int POLY_ORDER = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [COEF_W-1:0]        cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [TIME_W-1:0] s_drift_time,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_distance,
    output logic                     m_saturated
);

    // Orders above five treat the extra coefficients as zero, which is the same
    // as evaluating the fifth-order polynomial.
    localparam int ORD = (POLY_ORDER > MAX_ORDER) ? MAX_ORDER : POLY_ORDER;

    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];
    logic signed [TIME_W-1:0] knee_reg;
    logic signed [COEF_W-1:0] slope_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                coef_reg[k] <= '0;
            end
            knee_reg  <= KNEE_RESET;
            slope_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COEF_0: begin
                    coef_reg[0] <= cfg_wdata;
                end
                REG_COEF_1: begin
                    coef_reg[1] <= cfg_wdata;
                end
                REG_COEF_2: begin
                    coef_reg[2] <= cfg_wdata;
                end
                REG_COEF_3: begin
                    coef_reg[3] <= cfg_wdata;
                end
                REG_COEF_4: begin
                    coef_reg[4] <= cfg_wdata;
                end
                REG_COEF_5: begin
                    coef_reg[5] <= cfg_wdata;
                end
                REG_KNEE: begin
                    knee_reg <= cfg_wdata[TIME_W-1:0];
                end
                REG_SLOPE: begin
                    slope_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Stage chain: link 0 leaves the entry stages, link ORD enters the exit stages.
    logic                    link_valid [ORD+1];
    logic                    link_ready [ORD+1];
    logic signed [ACC_W-1:0] link_acc   [ORD+1];
    side_t                   link_side  [ORD+1];

    // The accumulator starts at the top coefficient in use.
    dtd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_time    (s_drift_time),
        .knee_time  (knee_reg),
        .tail_slope (slope_reg),
        .coef_top   (coef_reg[ORD]),
        .out_valid  (link_valid[0]),
        .out_ready  (link_ready[0]),
        .out_acc    (link_acc[0]),
        .out_side   (link_side[0])
    );

    // Step j folds in coefficient ORD-1-j, down to the constant term.
    for (genvar j = 0; j < ORD; j++) begin : g_step
        dtd_horner_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[j]),
            .in_ready  (link_ready[j]),
            .in_acc    (link_acc[j]),
            .in_side   (link_side[j]),
            .coef      (coef_reg[ORD-1-j]),
            .out_valid (link_valid[j+1]),
            .out_ready (link_ready[j+1]),
            .out_acc   (link_acc[j+1]),
            .out_side  (link_side[j+1])
        );
    end

    dtd_final u_final (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (link_valid[ORD]),
        .in_ready      (link_ready[ORD]),
        .in_acc        (link_acc[ORD]),
        .in_side       (link_side[ORD]),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_distance  (m_distance),
        .out_saturated (m_saturated)
    );

endmodule

>>> sv/dtd_front.sv
`timescale 1ns / 1ps
// Entry stages: knee compare, evaluation time select and tail product.
// Depends on dtd_pkg.
module dtd_front import dtd_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [TIME_W-1:0] in_time,
    input  logic signed [TIME_W-1:0] knee_time,
    input  logic signed [COEF_W-1:0] tail_slope,
    input  logic signed [COEF_W-1:0] coef_top,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ACC_W-1:0]  out_acc,
    output side_t                    out_side
);

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       take_reg;
    logic signed [TIME_W-1:0]   t_eval_reg;
    logic signed [EXCESS_W-1:0] excess_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    side_t                      side_reg;
    side_t                      side_next;
    logic                       ready2;
    logic                       take_tail;
    logic signed [EXCESS_W-1:0] excess;

    assign ready2   = !v2_reg || out_ready;
    assign in_ready = !v1_reg || ready2;

    assign take_tail = (in_time >= knee_time);
    assign excess    = $signed({in_time[TIME_W-1], in_time})
                     - $signed({knee_time[TIME_W-1], knee_time});

    always_comb begin
        side_next.t_eval    = t_eval_reg;
        side_next.tail_prod = take_reg ? TAIL_W'(tail_slope * excess_reg) : '0;
        side_next.sat       = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            take_reg   <= take_tail;
            t_eval_reg <= take_tail ? knee_time : in_time;
            excess_reg <= excess;
        end
        if (ready2) begin
            acc_reg  <= ACC_W'(coef_top);
            side_reg <= side_next;
        end
    end

    assign out_side  = side_reg;
    assign out_valid = v2_reg;
    assign out_acc   = acc_reg;

endmodule

>>> sv/dtd_horner_step.sv
`timescale 1ns / 1ps
// One Horner step in two stages: multiply, then round, add coefficient and clamp.
// Depends on dtd_pkg.
module dtd_horner_step import dtd_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ACC_W-1:0]  in_acc,
    input  side_t                    in_side,
    input  logic signed [COEF_W-1:0] coef,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ACC_W-1:0]  out_acc,
    output side_t                    out_side
);

    localparam int RND_W = PROD_W - ROUND_SHIFT;
    localparam int SUM_W = RND_W + 1;

    logic                     va_reg;
    logic                     vb_reg;
    logic signed [PROD_W-1:0] prod_reg;
    side_t                    side_a_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    side_t                    side_b_reg;
    side_t                    side_next;
    logic                     ready_b;
    logic signed [PROD_W-1:0] biased;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  sum;
    logic                     ovf;
    logic signed [ACC_W-1:0]  acc_next;

    assign ready_b  = !vb_reg || out_ready;
    assign in_ready = !va_reg || ready_b;

    // Floor of (p + half) / 2^14, so ties round toward plus infinity.
    assign biased = prod_reg + ROUND_BIAS;
    assign rnd    = $signed(biased[PROD_W-1:ROUND_SHIFT]);
    assign sum    = $signed({rnd[RND_W-1], rnd})
                  + $signed({{(SUM_W-COEF_W){coef[COEF_W-1]}}, coef});

    // Out of the accumulator range unless all bits above it copy its sign bit.
    assign ovf = !((&sum[SUM_W-1:ACC_W-1]) || !(|sum[SUM_W-1:ACC_W-1]));

    always_comb begin
        if (!ovf) begin
            acc_next = sum[ACC_W-1:0];
        end else if (sum[SUM_W-1]) begin
            acc_next = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            acc_next = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    always_comb begin
        side_next     = side_a_reg;
        side_next.sat = side_a_reg.sat | ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                va_reg <= in_valid;
            end
            if (ready_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            prod_reg   <= PROD_W'(in_acc * $signed(in_side.t_eval));
            side_a_reg <= in_side;
        end
        if (ready_b) begin
            acc_reg    <= acc_next;
            side_b_reg <= side_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_acc   = acc_reg;
    assign out_side  = side_b_reg;

endmodule

>>> sv/dtd_final.sv
`timescale 1ns / 1ps
// Exit stages: add the rounded tail term, then clamp to the 32-bit distance range.
// Depends on dtd_pkg.
module dtd_final import dtd_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [ACC_W-1:0] in_acc,
    input  side_t                   in_side,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] out_distance,
    output logic                    out_saturated
);

    localparam int RND_W = TAIL_W - ROUND_SHIFT;
    localparam int SUM_W = ACC_W + 1;

    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     sat1_reg;
    logic signed [OUT_W-1:0]  dist_reg;
    logic                     sat2_reg;
    logic                     ready2;
    logic signed [TAIL_W-1:0] biased;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  sum;
    logic                     ovf;
    logic signed [OUT_W-1:0]  dist_next;

    assign ready2   = !v2_reg || out_ready;
    assign in_ready = !v1_reg || ready2;

    // The tail product is zero on the polynomial branch, so it adds nothing there.
    assign biased = in_side.tail_prod + TAIL_BIAS;
    assign rnd    = $signed(biased[TAIL_W-1:ROUND_SHIFT]);
    assign sum    = $signed({in_acc[ACC_W-1], in_acc})
                  + $signed({{(SUM_W-RND_W){rnd[RND_W-1]}}, rnd});

    assign ovf = !((&sum_reg[SUM_W-1:OUT_W-1]) || !(|sum_reg[SUM_W-1:OUT_W-1]));

    always_comb begin
        if (!ovf) begin
            dist_next = sum_reg[OUT_W-1:0];
        end else if (sum_reg[SUM_W-1]) begin
            dist_next = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            dist_next = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            sum_reg  <= sum;
            sat1_reg <= in_side.sat;
        end
        if (ready2) begin
            dist_reg <= dist_next;
            sat2_reg <= sat1_reg | ovf;
        end
    end

    assign out_valid     = v2_reg;
    assign out_distance  = dist_reg;
    assign out_saturated = sat2_reg;

endmodule
